FILE: design/imcc_pkg.sv
// ---------------------------------------------------------------------------
// imcc_pkg: shared types and constants
// Beat types, widths and cell state for the center-to-corner matrix block.
// ---------------------------------------------------------------------------
package imcc_pkg;

    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned SPW       = 31;
    localparam int unsigned SZW       = 16;
    localparam int unsigned HW        = SPW + SZW;
    localparam int unsigned HL        = 24;
    localparam int unsigned HH        = HW - HL;
    localparam int unsigned SQW       = 2 * WORD_BITS + 1;
    localparam int unsigned RMW       = WORD_BITS + 2;
    localparam int unsigned DW        = WORD_BITS + 1;
    localparam int unsigned QB        = SPW + 1;
    localparam int unsigned NW        = WORD_BITS + SPW + 2;
    localparam int unsigned AW        = WORD_BITS + HW + 3;
    localparam int unsigned CFG_W     = 31;
    localparam int unsigned IDX_W     = 3;

    localparam logic [IDX_W-1:0] CFG_SIZE_I    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SIZE_J    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SIZE_K    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_SPACING_I = 3'd3;
    localparam logic [IDX_W-1:0] CFG_SPACING_J = 3'd4;
    localparam logic [IDX_W-1:0] CFG_SPACING_K = 3'd5;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] col_t_x;
        logic signed [WORD_BITS-1:0] col_t_y;
        logic signed [WORD_BITS-1:0] col_t_z;
        logic signed [WORD_BITS-1:0] col_s_x;
        logic signed [WORD_BITS-1:0] col_s_y;
        logic signed [WORD_BITS-1:0] col_s_z;
        logic signed [WORD_BITS-1:0] col_n_x;
        logic signed [WORD_BITS-1:0] col_n_y;
        logic signed [WORD_BITS-1:0] col_n_z;
        logic signed [WORD_BITS-1:0] center_x;
        logic signed [WORD_BITS-1:0] center_y;
        logic signed [WORD_BITS-1:0] center_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] out_i_x;
        logic signed [WORD_BITS-1:0] out_i_y;
        logic signed [WORD_BITS-1:0] out_i_z;
        logic signed [WORD_BITS-1:0] out_j_x;
        logic signed [WORD_BITS-1:0] out_j_y;
        logic signed [WORD_BITS-1:0] out_j_z;
        logic signed [WORD_BITS-1:0] out_k_x;
        logic signed [WORD_BITS-1:0] out_k_y;
        logic signed [WORD_BITS-1:0] out_k_z;
        logic signed [WORD_BITS-1:0] corner_x;
        logic signed [WORD_BITS-1:0] corner_y;
        logic signed [WORD_BITS-1:0] corner_z;
    } t_out_beat;

    typedef struct packed {
        logic [SQW-1:0] rem;
        logic [SQW-1:0] root;
    } t_sqrt_st;

    typedef struct packed {
        logic [RMW-1:0] rem;
        logic [QB-1:0]  low;
        logic [DW-1:0]  den;
        logic           zero;
    } t_div_st;

    localparam logic signed [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    function automatic logic [WORD_BITS-1:0] sat_q(input logic signed [QB:0] v);
        logic signed [QB:0] hi;
        logic signed [QB:0] lo;
        hi = (QB+1)'(SMAX);
        lo = (QB+1)'(SMIN);
        if (v > hi) return SMAX;
        if (v < lo) return SMIN;
        return v[WORD_BITS-1:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] sat_a(
        input logic signed [AW-FRAC_BITS-2:0] v
    );
        logic signed [AW-FRAC_BITS-2:0] hi;
        logic signed [AW-FRAC_BITS-2:0] lo;
        hi = (AW-FRAC_BITS-1)'(SMAX);
        lo = (AW-FRAC_BITS-1)'(SMIN);
        if (v > hi) return SMAX;
        if (v < lo) return SMIN;
        return v[WORD_BITS-1:0];
    endfunction

endpackage

FILE: design/image_matrix_center_to_corner.sv
// ---------------------------------------------------------------------------
// image_matrix_center_to_corner: center-origin to corner-origin matrix
// Normalizes and scales three direction columns and shifts the origin.
// ---------------------------------------------------------------------------
//  channel   signals                              beat
//  input     i_valid, o_ready, i_data             one center-origin matrix
//  output    o_valid, i_ready, o_data             one corner-origin matrix
//  config    i_cfg_we, i_cfg_idx, i_cfg_data      one register write
//
//  One matrix per cycle while the skid register is empty. An input beat
//  passes three front stages, 32 square root cells, one numerator stage,
//  32 division cells, one result stage and the output register.
//  Synchronous reset clears all valid flags and loads the register defaults.
//  An output skid register takes one result under stall; the pipeline and
//  o_ready hold while it is full.
// ---------------------------------------------------------------------------
module image_matrix_center_to_corner (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  imcc_pkg::t_in_beat                   i_data,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output imcc_pkg::t_out_beat                  o_data,
    input  logic                                 i_cfg_we,
    input  logic [imcc_pkg::IDX_W-1:0]           i_cfg_idx,
    input  logic [imcc_pkg::CFG_W-1:0]           i_cfg_data
);
    localparam int unsigned W      = imcc_pkg::WORD_BITS;
    localparam int unsigned F      = imcc_pkg::FRAC_BITS;
    localparam int unsigned SPW    = imcc_pkg::SPW;
    localparam int unsigned SZW    = imcc_pkg::SZW;
    localparam int unsigned HW     = imcc_pkg::HW;
    localparam int unsigned HL     = imcc_pkg::HL;
    localparam int unsigned HH     = imcc_pkg::HH;
    localparam int unsigned SQW    = imcc_pkg::SQW;
    localparam int unsigned RMW    = imcc_pkg::RMW;
    localparam int unsigned QB     = imcc_pkg::QB;
    localparam int unsigned NW     = imcc_pkg::NW;
    localparam int unsigned AW     = imcc_pkg::AW;
    localparam int unsigned LEN_ST = 2 + W;
    localparam int unsigned FIN_ST = 4 + W + QB;
    localparam int unsigned NST    = FIN_ST + 1;

    // configuration
    logic [SZW-1:0] r_size [3];
    logic [SPW-1:0] r_sp   [3];
    logic [HW-1:0]  r_half [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                r_size[c] <= SZW'(1);
                r_sp[c]   <= SPW'(1) << F;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                imcc_pkg::CFG_SIZE_I:    r_size[0] <= i_cfg_data[SZW-1:0];
                imcc_pkg::CFG_SIZE_J:    r_size[1] <= i_cfg_data[SZW-1:0];
                imcc_pkg::CFG_SIZE_K:    r_size[2] <= i_cfg_data[SZW-1:0];
                imcc_pkg::CFG_SPACING_I: r_sp[0]   <= i_cfg_data[SPW-1:0];
                imcc_pkg::CFG_SPACING_J: r_sp[1]   <= i_cfg_data[SPW-1:0];
                imcc_pkg::CFG_SPACING_K: r_sp[2]   <= i_cfg_data[SPW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_half[c] <= HW'(r_sp[c]) *
                HW'((r_size[c] == '0) ? SZW'(0) : (r_size[c] - SZW'(1)));
        end
    end

    // flow control
    logic                r_ov;
    logic                r_sv;
    imcc_pkg::t_out_beat r_out;
    imcc_pkg::t_out_beat r_skid;
    logic                w_en;
    logic [NST-1:0]      r_vld;
    imcc_pkg::t_out_beat r_fin;

    assign w_en    = ~r_sv;
    assign o_ready = w_en;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (i_ready) begin
                r_out <= r_skid;
                r_sv  <= 1'b0;
            end
        end else if (!r_ov || i_ready) begin
            r_ov <= r_vld[FIN_ST];
            if (r_vld[FIN_ST]) r_out <= r_fin;
        end else if (r_vld[FIN_ST]) begin
            r_skid <= r_fin;
            r_sv   <= 1'b1;
        end
    end

    // front stages
    logic signed [W-1:0] w_in [12];
    logic [W-1:0]        r_mag [0:LEN_ST][9];
    logic [8:0]          r_neg [0:FIN_ST-1];
    logic signed [W-1:0] r_ctr [0:2][3];
    logic [2*W-1:0]      r_sq  [9];
    logic [W+HL-1:0]     r_plo [9];
    logic [W+HH-1:0]     r_phi [9];
    logic [2*W-1:0]      r_s   [3];
    logic [W+HW-1:0]     r_t   [9];
    logic signed [AW-1:0] r_acc [3];
    logic [W-1:0]        r_corn [4:FIN_ST-1][3];
    logic signed [AW-1:0] n_acc [3];

    always_comb begin
        w_in[0]  = i_data.col_t_x;
        w_in[1]  = i_data.col_t_y;
        w_in[2]  = i_data.col_t_z;
        w_in[3]  = i_data.col_s_x;
        w_in[4]  = i_data.col_s_y;
        w_in[5]  = i_data.col_s_z;
        w_in[6]  = i_data.col_n_x;
        w_in[7]  = i_data.col_n_y;
        w_in[8]  = i_data.col_n_z;
        w_in[9]  = i_data.center_x;
        w_in[10] = i_data.center_y;
        w_in[11] = i_data.center_z;
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_acc[r] = (AW'(r_ctr[2][r]) <<< (F + 1)) + (AW'(1) << F);
            for (int c = 0; c < 3; c++) begin
                if (r_neg[2][c*3+r]) n_acc[r] = n_acc[r] + AW'(r_t[c*3+r]);
                else                 n_acc[r] = n_acc[r] - AW'(r_t[c*3+r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_neg[0][k] <= w_in[k][W-1];
                r_mag[0][k] <= w_in[k][W-1] ? (~w_in[k] + W'(1)) : w_in[k];
                r_sq[k]  <= (2*W)'(r_mag[0][k]) * (2*W)'(r_mag[0][k]);
                r_plo[k] <= (W+HL)'(r_mag[0][k]) * (W+HL)'(r_half[k/3][HL-1:0]);
                r_phi[k] <= (W+HH)'(r_mag[0][k]) * (W+HH)'(r_half[k/3][HW-1:HL]);
                r_t[k]   <= {r_phi[k], {HL{1'b0}}} + (W+HW)'(r_plo[k]);
            end
            for (int r = 0; r < 3; r++) begin
                r_ctr[0][r] <= w_in[9+r];
                r_ctr[1][r] <= r_ctr[0][r];
                r_ctr[2][r] <= r_ctr[1][r];
                r_acc[r]    <= n_acc[r];
                r_corn[4][r] <= imcc_pkg::sat_a((AW-F-1)'(r_acc[r] >>> (F + 1)));
            end
            for (int c = 0; c < 3; c++) begin
                r_s[c] <= r_sq[c*3] + r_sq[c*3+1] + r_sq[c*3+2];
            end
            for (int i = 1; i <= LEN_ST; i++) r_mag[i] <= r_mag[i-1];
            for (int i = 1; i < FIN_ST; i++) r_neg[i] <= r_neg[i-1];
            for (int i = 5; i < FIN_ST; i++) r_corn[i] <= r_corn[i-1];
        end
    end

    // square root cells, one chain per column
    imcc_pkg::t_sqrt_st w_sq [3][0:W];

    for (genvar c = 0; c < 3; c++) begin : g_sqrt
        assign w_sq[c][0] = '{rem: SQW'(r_s[c]), root: '0};
        for (genvar k = 0; k < W; k++) begin : g_cell
            imcc_sqrt_cell #(.BIT_POS(W - 1 - k)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_st  (w_sq[c][k]),
                .o_st  (w_sq[c][k+1])
            );
        end
    end

    // numerator stage and division cells
    imcc_pkg::t_div_st r_dv0 [9];
    imcc_pkg::t_div_st w_dv  [9][0:QB];
    logic [W-1:0]      w_len [3];
    logic [NW-1:0]     w_num [9];

    always_comb begin
        for (int c = 0; c < 3; c++) w_len[c] = w_sq[c][W].root[W-1:0];
        for (int k = 0; k < 9; k++) begin
            w_num[k] = NW'(r_mag[LEN_ST][k]) * NW'({r_sp[k/3], 1'b0})
                     + NW'(w_len[k/3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_dv0[k].rem  <= RMW'(w_num[k][NW-1:QB]);
                r_dv0[k].low  <= w_num[k][QB-1:0];
                r_dv0[k].den  <= {w_len[k/3], 1'b0};
                r_dv0[k].zero <= (w_len[k/3] == '0);
            end
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_div
        assign w_dv[k][0] = r_dv0[k];
        for (genvar j = 0; j < QB; j++) begin : g_cell
            imcc_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_st  (w_dv[k][j]),
                .o_st  (w_dv[k][j+1])
            );
        end
    end

    // result stage
    logic [W-1:0]      w_col [9];
    logic signed [QB:0] w_sv [9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_sv[k] = $signed({1'b0, w_dv[k][QB].low});
            if (r_neg[FIN_ST-1][k]) w_sv[k] = -w_sv[k];
            w_col[k] = w_dv[k][QB].zero ? '0 : imcc_pkg::sat_q(w_sv[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin <= {w_col[0], w_col[1], w_col[2], w_col[3], w_col[4], w_col[5],
                      w_col[6], w_col[7], w_col[8], r_corn[FIN_ST-1][0],
                      r_corn[FIN_ST-1][1], r_corn[FIN_ST-1][2]};
        end
    end

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid full without output beat");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready && !r_sv && r_vld[FIN_ST]) |=> r_sv)
        else $error("result beat dropped under stall");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && i_ready) |=> !r_sv) else $error("skid did not drain");

endmodule

FILE: design/imcc_sqrt_cell.sv
// ---------------------------------------------------------------------------
// imcc_sqrt_cell: one digit of the integer square root
// Tries one result bit against the remaining radicand and passes the state on.
// ---------------------------------------------------------------------------
module imcc_sqrt_cell #(
    parameter int unsigned BIT_POS = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  imcc_pkg::t_sqrt_st  i_st,
    output imcc_pkg::t_sqrt_st  o_st
);
    localparam int unsigned SQW = imcc_pkg::SQW;
    localparam logic [SQW-1:0] BIT = {{(SQW-1){1'b0}}, 1'b1} << (2 * BIT_POS);

    imcc_pkg::t_sqrt_st r_st;
    imcc_pkg::t_sqrt_st n_st;
    logic [SQW-1:0]     w_trial;

    always_comb begin
        w_trial = i_st.root + BIT;
        if (i_st.rem >= w_trial) begin
            n_st.rem  = i_st.rem - w_trial;
            n_st.root = (i_st.root >> 1) + BIT;
        end else begin
            n_st.rem  = i_st.rem;
            n_st.root = i_st.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_st <= n_st;
    end

    assign o_st = r_st;
endmodule

FILE: design/imcc_div_cell.sv
// ---------------------------------------------------------------------------
// imcc_div_cell: one restoring division step
// Shifts one numerator bit into the remainder and one quotient bit out.
// ---------------------------------------------------------------------------
module imcc_div_cell (
    input  logic               i_clk,
    input  logic               i_en,
    input  imcc_pkg::t_div_st  i_st,
    output imcc_pkg::t_div_st  o_st
);
    localparam int unsigned RMW = imcc_pkg::RMW;
    localparam int unsigned QB  = imcc_pkg::QB;

    imcc_pkg::t_div_st r_st;
    imcc_pkg::t_div_st n_st;
    logic [RMW-1:0]    w_part;
    logic [RMW-1:0]    w_den;

    always_comb begin
        w_part    = {i_st.rem[RMW-2:0], i_st.low[QB-1]};
        w_den     = RMW'(i_st.den);
        n_st.den  = i_st.den;
        n_st.zero = i_st.zero;
        if (w_part >= w_den) begin
            n_st.rem = w_part - w_den;
            n_st.low = {i_st.low[QB-2:0], 1'b1};
        end else begin
            n_st.rem = w_part;
            n_st.low = {i_st.low[QB-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_st <= n_st;
    end

    assign o_st = r_st;
endmodule

FILE: bench/imcc_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// imcc_checker: scoreboard for the center-to-corner matrix block
// Snoops the register port and both beat channels, predicts each corner
// matrix from the accepted input beat and compares it field by field.
// ---------------------------------------------------------------------------
module imcc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  imcc_pkg::t_in_beat                i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  imcc_pkg::t_out_beat               i_out_data,
    input  logic                              i_cfg_we,
    input  logic [imcc_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [imcc_pkg::CFG_W-1:0]        i_cfg_data,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_beats_in,
    output int                                o_beats_out
);
    logic [15:0]          size_q [3];
    logic [30:0]          spacing_q [3];
    imcc_pkg::t_out_beat  matrix_q [$];

    function automatic logic [31:0] sat_word(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return imcc_pkg::SMAX;
        if (v < -128'sd2147483648) return imcc_pkg::SMIN;
        return v[31:0];
    endfunction

    function automatic logic [127:0] floor_sqrt(input logic [127:0] s);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= s) r = c;
        end
        return r;
    endfunction

    function automatic imcc_pkg::t_out_beat corner_matrix(input imcc_pkg::t_in_beat b);
        logic [32*12-1:0]     flat;
        logic [31:0]          w [12];
        logic [127:0]         mag [12];
        logic                 neg [12];
        logic [32*12-1:0]     res;
        logic [127:0]         sq;
        logic [127:0]         len;
        logic [127:0]         q;
        logic [127:0]         half;
        logic [127:0]         t;
        logic signed [127:0]  acc;
        flat = b;
        for (int i = 0; i < 12; i++) begin
            w[i] = flat[32*(11-i) +: 32];
            neg[i] = w[i][31];
            mag[i] = neg[i] ? (128'd0 - {{96{1'b1}}, w[i]}) : {96'd0, w[i]};
        end
        for (int c = 0; c < 3; c++) begin
            sq = mag[3*c]*mag[3*c] + mag[3*c+1]*mag[3*c+1] + mag[3*c+2]*mag[3*c+2];
            len = floor_sqrt(sq);
            for (int r = 0; r < 3; r++) begin
                q = 0;
                if (len != 0)
                    q = (mag[3*c+r] * {97'd0, spacing_q[c]} * 2 + len) / (len * 2);
                res[32*(11-(3*c+r)) +: 32] =
                    sat_word(neg[3*c+r] ? -$signed(q) : $signed(q));
            end
        end
        for (int r = 0; r < 3; r++) begin
            acc = $signed({{96{w[9+r][31]}}, w[9+r]}) <<< (imcc_pkg::FRAC_BITS + 1);
            for (int c = 0; c < 3; c++) begin
                half = {97'd0, spacing_q[c]} *
                       ((size_q[c] == 0) ? 128'd0 : {112'd0, size_q[c]} - 1);
                t = mag[3*c+r] * half;
                acc = neg[3*c+r] ? acc + $signed(t) : acc - $signed(t);
            end
            acc = (acc + (128'sd1 <<< imcc_pkg::FRAC_BITS)) >>> (imcc_pkg::FRAC_BITS + 1);
            res[32*(2-r) +: 32] = sat_word(acc);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        imcc_pkg::t_out_beat want;
        logic [32*12-1:0] wf;
        logic [32*12-1:0] gf;
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                size_q[a] <= 16'd1;
                spacing_q[a] <= 31'd65536;
            end
            matrix_q.delete();
            o_errors <= 0;
            o_beats_in <= 0;
            o_beats_out <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                matrix_q.push_back(corner_matrix(i_in_data));
                o_beats_in <= o_beats_in + 1;
            end
            if (i_out_valid && i_out_ready) begin
                o_beats_out <= o_beats_out + 1;
                if (matrix_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected output beat %h", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = matrix_q.pop_front();
                    wf = want;
                    gf = i_out_data;
                    if (wf != gf) begin
                        for (int f = 0; f < 12; f++)
                            if (wf[32*(11-f) +: 32] != gf[32*(11-f) +: 32] && o_errors < 10)
                                $display("beat %0d field %0d: expected %h got %h",
                                         o_beats_out, f, wf[32*(11-f) +: 32],
                                         gf[32*(11-f) +: 32]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    imcc_pkg::CFG_SIZE_I:    size_q[0] <= i_cfg_data[15:0];
                    imcc_pkg::CFG_SIZE_J:    size_q[1] <= i_cfg_data[15:0];
                    imcc_pkg::CFG_SIZE_K:    size_q[2] <= i_cfg_data[15:0];
                    imcc_pkg::CFG_SPACING_I: spacing_q[0] <= i_cfg_data[30:0];
                    imcc_pkg::CFG_SPACING_J: spacing_q[1] <= i_cfg_data[30:0];
                    imcc_pkg::CFG_SPACING_K: spacing_q[2] <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_pending = matrix_q.size();

endmodule

FILE: bench/tb_image_matrix_center_to_corner.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_image_matrix_center_to_corner: top of the matrix conversion bench
// Drives directed and random matrices under several register settings with
// random idling on both channels and a long output stall; the checker
// predicts and compares every result beat.
// ---------------------------------------------------------------------------
module tb_image_matrix_center_to_corner;

    localparam int WATCHDOG = 3000;
    localparam int IW = imcc_pkg::IDX_W;
    localparam int CW = imcc_pkg::CFG_W;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    imcc_pkg::t_in_beat   i_data;
    logic                 o_valid;
    logic                 i_ready;
    imcc_pkg::t_out_beat  o_data;
    logic                 i_cfg_we;
    logic [IW-1:0]        i_cfg_idx;
    logic [CW-1:0]        i_cfg_data;

    int                 errors;
    int                 pending;
    int                 beats_in;
    int                 beats_out;
    int                 quiet_cycles;
    int                 settings_run;
    logic               calm;

    image_matrix_center_to_corner u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    imcc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending),
        .o_beats_in(beats_in), .o_beats_out(beats_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return imcc_pkg::SMAX;
            1: return imcc_pkg::SMIN;
            2: return 32'd0;
            3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic imcc_pkg::t_in_beat pick_matrix();
        logic [32*12-1:0] f;
        for (int i = 0; i < 12; i++) f[32*i +: 32] = pick_word();
        return f;
    endfunction

    function automatic imcc_pkg::t_in_beat fill_matrix(input logic [31:0] col,
                                                       input logic [31:0] ctr);
        logic [32*12-1:0] f;
        for (int i = 0; i < 12; i++) f[32*(11-i) +: 32] = (i < 9) ? col : ctr;
        return f;
    endfunction

    task automatic send(input imcc_pkg::t_in_beat m);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= m;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // hold until every result is back, then let the pipeline drain
    task automatic settle();
        i_valid <= 1'b0;
        i_cfg_we <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic load_setting(input int mode);
        logic [CW-1:0] v;
        settle();
        for (int r = 0; r < 6; r++) begin
            case (mode)
                0: v = (r < 3) ? 31'd65535 : 31'h7FFF_FFFF;
                1: v = (r < 3) ? 31'($urandom_range(0, 2)) : 31'($urandom_range(0, 1));
                2: v = (r < 3) ? 31'($urandom_range(1, 512)) : 31'($urandom_range(1, 1 << 18));
                default: v = CW'($urandom);
            endcase
            write_reg(r[IW-1:0], v);
        end
        write_reg(IW'(6), CW'($urandom));
        write_reg(IW'(7), CW'($urandom));
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    // sink side: random stall bursts, one long hold while input keeps coming
    initial begin
        bit held;
        held = 0;
        i_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && beats_in > 120) begin
                held = 1;
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            if (!calm && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // abort when no beat moves for too long
    initial begin
        int last_in;
        int last_out;
        quiet_cycles = 0;
        last_in = 0;
        last_out = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (beats_in != last_in || beats_out != last_out) quiet_cycles = 0;
            else quiet_cycles++;
            last_in = beats_in;
            last_out = beats_out;
            if (quiet_cycles >= WATCHDOG) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        calm = 0;
        settings_run = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(fill_matrix(32'd0, 32'd0));
        send(fill_matrix(imcc_pkg::SMAX, imcc_pkg::SMAX));
        send(fill_matrix(imcc_pkg::SMIN, imcc_pkg::SMIN));
        send(fill_matrix(32'h0001_0000, 32'h0000_8000));
        send(fill_matrix(32'hFFFF_0000, 32'hFFFF_8000));
        send(fill_matrix(32'd1, 32'hFFFF_FFFF));
        send(fill_matrix(32'hFFFF_FFFF, 32'd1));
        send({imcc_pkg::SMAX, 32'd0, 32'd0, 32'd0, imcc_pkg::SMIN, 32'd0, 32'd0,
              32'd0, 32'd3, 32'd0, 32'd0, 32'd0});
        load_setting(0);
        send(fill_matrix(imcc_pkg::SMAX, imcc_pkg::SMIN));
        send(fill_matrix(imcc_pkg::SMIN, imcc_pkg::SMAX));
        send(fill_matrix(32'h0001_0000, 32'd0));
        send({96'd0, imcc_pkg::SMIN, imcc_pkg::SMIN, imcc_pkg::SMIN, 96'd0,
              imcc_pkg::SMAX, 32'd0, imcc_pkg::SMIN});
        load_setting(1);
        repeat (4) send(fill_matrix(32'h0003_0000, 32'h0010_0000));
        repeat (4) send(pick_matrix());

        for (int ph = 0; ph < 5; ph++) begin
            load_setting((ph == 1) ? 0 : (ph == 3) ? 1 : (ph % 2) ? 3 : 2);
            if (ph == 4) calm = 1;
            repeat (150) send(pick_matrix());
        end

        settle();
        $display("%0d matrices in, %0d out, %0d register settings incl. extremes",
                 beats_in, beats_out, settings_run);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/imcc_pkg.sv
design/imcc_sqrt_cell.sv
design/imcc_div_cell.sv
design/image_matrix_center_to_corner.sv
bench/imcc_checker.sv
bench/tb_image_matrix_center_to_corner.sv
